// ===== rtl/visual_servo_aim_angle_macros.svh =====
// assertion macros for visual_servo_aim_angle
`ifndef VISUAL_SERVO_AIM_ANGLE_MACROS_SVH
`define VISUAL_SERVO_AIM_ANGLE_MACROS_SVH

`ifndef SYNTHESIS

`define VSAA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define VSAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define VSAA_ASSERT_IMP(lbl, ante, cons)

`define VSAA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/vsaa_pkg.sv =====
`timescale 1ns / 1ps

package vsaa_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int PIX_FIELD_W = 12;
  localparam int PIX_W = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
  localparam int ERR_W = PIX_W + 1;
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int GAIN_W = 20;
  localparam int WEIGHT_W = 16;
  localparam int P1_W = ERR_W + GAIN_W + 1;
  localparam int P2_W = P1_W + WEIGHT_W + 1;
  localparam int SUM_W = P2_W + 1;
  localparam int FRAC_BITS = 30;
  localparam int RES_W = SUM_W - FRAC_BITS;
  localparam int PAN_W = 12;
  localparam int TILT_W = 11;

  localparam int IN_W = 72;
  localparam int OUT_W = 24;
  localparam int CFG_W = 20;
  localparam int IDX_W = 3;

  localparam int DIV_STEPS = WEIGHT_W;
  localparam int WEIGHT_NUM = 3000 * 16384;
  localparam int DIV_INIT = WEIGHT_NUM >> DIV_STEPS;
  localparam int NEAR_MM = 100;
  localparam int SAT_MM = DIV_INIT;

  localparam int V_WT = DIV_STEPS + 1;
  localparam int V_M1 = DIV_STEPS + 2;
  localparam int V_M2 = DIV_STEPS + 3;
  localparam int V_SM = DIV_STEPS + 4;
  localparam int V_RD = DIV_STEPS + 5;
  localparam int V_OUT = DIV_STEPS + 6;

  localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(16384);
  localparam logic [WEIGHT_W-1:0] W_MIN = WEIGHT_W'(8192);
  localparam logic [WEIGHT_W-1:0] W_MAX = WEIGHT_W'(32768);

  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_PAN = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_TILT = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAN_MIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAN_MAX = 3'd5;
  localparam logic [IDX_W-1:0] REG_TILT_MIN = 3'd6;
  localparam logic [IDX_W-1:0] REG_TILT_MAX = 3'd7;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [P1_W-1:0] p1_t;
  typedef logic signed [P2_W-1:0] p2_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [RES_W-1:0] res_t;

  localparam sum_t RND_UP = sum_t'(64'd1 << (FRAC_BITS - 1));
  localparam sum_t RND_DN = sum_t'((64'd1 << (FRAC_BITS - 1)) - 64'd1);

  typedef struct packed {
    logic near;
    logic sat;
    logic [RANGE_W-1:0] dvsr;
    logic [RANGE_W-1:0] rem;
    logic [WEIGHT_W-1:0] quo;
    err_t ex;
    err_t ey;
    angle_t cp;
    angle_t ct;
  } div_stage_t;

  typedef struct packed {
    logic near;
    logic [WEIGHT_W-1:0] w;
    err_t ex;
    err_t ey;
    angle_t cp;
    angle_t ct;
  } wt_stage_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] w;
    p1_t pe;
    p1_t te;
    angle_t cp;
    angle_t ct;
  } m1_stage_t;

  typedef struct packed {
    p2_t pm;
    p2_t tm;
    angle_t cp;
    angle_t ct;
  } m2_stage_t;

endpackage

// ===== rtl/visual_servo_aim_angle.sv =====
`timescale 1ns / 1ps

// Aim angle pipeline: one detection transfer per clock while the output is not stalled,
// one aim transfer out per input. The pipeline has 23 register stages, and output valid
// is the valid bit of the last of them.
// One stage captures the input and the pixel errors, 16 are the pipelined divider that
// forms the range weight 3000/range_mm, one quotient bit per stage, followed by the weight
// clamp, two multiplier stages, the angle sum, rounding and the soft limit clamp. A stall
// on the output freezes the whole pipeline. A configuration write also reaches items in
// flight, so configuration registers should be changed only while no item is in flight.

`include "visual_servo_aim_angle_macros.svh"

module visual_servo_aim_angle (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_col, pixel_row, range_mm, current_pan, current_tilt
  input  logic [vsaa_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // aim_pan, aim_tilt, zero pad
  output logic [vsaa_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_wr_en,
  input  logic [vsaa_pkg::IDX_W-1:0]    cfg_index,
  input  logic [vsaa_pkg::CFG_W-1:0]    cfg_wdata
);

  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [vsaa_pkg::GAIN_W-1:0] gain_pan;
  logic [vsaa_pkg::GAIN_W-1:0] gain_tilt;
  logic [vsaa_pkg::PAN_W-1:0] pan_min;
  logic [vsaa_pkg::PAN_W-1:0] pan_max;
  logic signed [vsaa_pkg::TILT_W-1:0] tilt_min;
  logic signed [vsaa_pkg::TILT_W-1:0] tilt_max;

  logic adv;
  logic [vsaa_pkg::V_OUT:0] vld;

  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  logic [vsaa_pkg::RANGE_W-1:0] range_mm;
  vsaa_pkg::div_stage_t dv_in;
  vsaa_pkg::div_stage_t dv [vsaa_pkg::DIV_STEPS+1];
  vsaa_pkg::div_stage_t dv_next [vsaa_pkg::DIV_STEPS];
  logic [vsaa_pkg::RANGE_W:0] dv_shl [vsaa_pkg::DIV_STEPS];

  vsaa_pkg::wt_stage_t wt;
  vsaa_pkg::wt_stage_t wt_next;
  vsaa_pkg::m1_stage_t m1;
  vsaa_pkg::m1_stage_t m1_next;
  vsaa_pkg::m2_stage_t m2;
  vsaa_pkg::m2_stage_t m2_next;
  vsaa_pkg::sum_t ps;
  vsaa_pkg::sum_t ts;
  vsaa_pkg::sum_t ps_rnd;
  vsaa_pkg::sum_t ts_rnd;
  vsaa_pkg::res_t pr;
  vsaa_pkg::res_t tr;
  vsaa_pkg::res_t pan_lo;
  vsaa_pkg::res_t pan_hi;
  vsaa_pkg::res_t tilt_lo;
  vsaa_pkg::res_t tilt_hi;
  vsaa_pkg::res_t pan_c1;
  vsaa_pkg::res_t pan_c2;
  vsaa_pkg::res_t tilt_c1;
  vsaa_pkg::res_t tilt_c2;
  logic [vsaa_pkg::PAN_W-1:0] aim_pan;
  logic signed [vsaa_pkg::TILT_W-1:0] aim_tilt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 12'd960;
      center_y <= 12'd540;
      gain_pan <= vsaa_pkg::GAIN_W'(20480);
      gain_tilt <= vsaa_pkg::GAIN_W'(20480);
      pan_min <= '0;
      pan_max <= vsaa_pkg::PAN_W'(3600);
      tilt_min <= -11'sd300;
      tilt_max <= 11'sd900;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vsaa_pkg::REG_CENTER_X: center_x <= cfg_wdata[11:0];
        vsaa_pkg::REG_CENTER_Y: center_y <= cfg_wdata[11:0];
        vsaa_pkg::REG_GAIN_PAN: gain_pan <= cfg_wdata;
        vsaa_pkg::REG_GAIN_TILT: gain_tilt <= cfg_wdata;
        vsaa_pkg::REG_PAN_MIN: pan_min <= cfg_wdata[vsaa_pkg::PAN_W-1:0];
        vsaa_pkg::REG_PAN_MAX: pan_max <= cfg_wdata[vsaa_pkg::PAN_W-1:0];
        vsaa_pkg::REG_TILT_MIN: tilt_min <= cfg_wdata[vsaa_pkg::TILT_W-1:0];
        vsaa_pkg::REG_TILT_MAX: tilt_max <= cfg_wdata[vsaa_pkg::TILT_W-1:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  assign adv = !vld[vsaa_pkg::V_OUT] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[vsaa_pkg::V_OUT-1:0], s_axis_tvalid};
    end
  end

  // input unpack and pixel errors
  assign pixel_col = s_axis_tdata[11:0];
  assign pixel_row = s_axis_tdata[23:12];
  assign range_mm = s_axis_tdata[39:24];

  always_comb begin
    dv_in.near = (range_mm <= vsaa_pkg::RANGE_W'(vsaa_pkg::NEAR_MM));
    dv_in.sat = (range_mm <= vsaa_pkg::RANGE_W'(vsaa_pkg::SAT_MM));
    dv_in.dvsr = range_mm;
    dv_in.rem = vsaa_pkg::RANGE_W'(vsaa_pkg::DIV_INIT);
    dv_in.quo = '0;
    dv_in.ex = vsaa_pkg::err_t'({1'b0, pixel_col[vsaa_pkg::PIX_W-1:0]})
             - vsaa_pkg::err_t'({1'b0, center_x[vsaa_pkg::PIX_W-1:0]});
    dv_in.ey = vsaa_pkg::err_t'({1'b0, center_y[vsaa_pkg::PIX_W-1:0]})
             - vsaa_pkg::err_t'({1'b0, pixel_row[vsaa_pkg::PIX_W-1:0]});
    dv_in.cp = s_axis_tdata[55:40];
    dv_in.ct = s_axis_tdata[71:56];
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < vsaa_pkg::DIV_STEPS; k++) begin
      dv_next[k] = dv[k];
      dv_shl[k] = {dv[k].rem, 1'b0};
      if (dv_shl[k] >= {1'b0, dv[k].dvsr}) begin
        dv_next[k].rem = vsaa_pkg::RANGE_W'(dv_shl[k] - {1'b0, dv[k].dvsr});
        dv_next[k].quo = {dv[k].quo[vsaa_pkg::WEIGHT_W-2:0], 1'b1};
      end else begin
        dv_next[k].rem = dv_shl[k][vsaa_pkg::RANGE_W-1:0];
        dv_next[k].quo = {dv[k].quo[vsaa_pkg::WEIGHT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv_in;
      for (int k = 1; k <= vsaa_pkg::DIV_STEPS; k++) begin
        dv[k] <= dv_next[k-1];
      end
    end
  end

  // weight select and clamp
  always_comb begin
    wt_next.near = dv[vsaa_pkg::DIV_STEPS].near;
    wt_next.ex = dv[vsaa_pkg::DIV_STEPS].ex;
    wt_next.ey = dv[vsaa_pkg::DIV_STEPS].ey;
    wt_next.cp = dv[vsaa_pkg::DIV_STEPS].cp;
    wt_next.ct = dv[vsaa_pkg::DIV_STEPS].ct;
    priority if (dv[vsaa_pkg::DIV_STEPS].near) begin
      wt_next.w = vsaa_pkg::W_ONE;
    end else if (dv[vsaa_pkg::DIV_STEPS].sat) begin
      wt_next.w = vsaa_pkg::W_MAX;
    end else if (dv[vsaa_pkg::DIV_STEPS].quo > vsaa_pkg::W_MAX) begin
      wt_next.w = vsaa_pkg::W_MAX;
    end else if (dv[vsaa_pkg::DIV_STEPS].quo < vsaa_pkg::W_MIN) begin
      wt_next.w = vsaa_pkg::W_MIN;
    end else begin
      wt_next.w = dv[vsaa_pkg::DIV_STEPS].quo;
    end
  end

  // error times gain
  always_comb begin
    m1_next.w = wt.w;
    m1_next.pe = wt.ex * $signed({1'b0, gain_pan});
    m1_next.te = wt.ey * $signed({1'b0, gain_tilt});
    m1_next.cp = wt.cp;
    m1_next.ct = wt.ct;
  end

  // times range weight
  always_comb begin
    m2_next.pm = m1.pe * $signed({1'b0, m1.w});
    m2_next.tm = m1.te * $signed({1'b0, m1.w});
    m2_next.cp = m1.cp;
    m2_next.ct = m1.ct;
  end

  // round half away from zero
  always_comb begin
    ps_rnd = ps + (ps[vsaa_pkg::SUM_W-1] ? vsaa_pkg::RND_DN : vsaa_pkg::RND_UP);
    ts_rnd = ts + (ts[vsaa_pkg::SUM_W-1] ? vsaa_pkg::RND_DN : vsaa_pkg::RND_UP);
  end

  // soft limits, lower first then upper
  always_comb begin
    pan_lo = vsaa_pkg::res_t'($signed({1'b0, pan_min}));
    pan_hi = vsaa_pkg::res_t'($signed({1'b0, pan_max}));
    tilt_lo = vsaa_pkg::res_t'(tilt_min);
    tilt_hi = vsaa_pkg::res_t'(tilt_max);
    pan_c1 = (pr < pan_lo) ? pan_lo : pr;
    pan_c2 = (pan_c1 > pan_hi) ? pan_hi : pan_c1;
    tilt_c1 = (tr < tilt_lo) ? tilt_lo : tr;
    tilt_c2 = (tilt_c1 > tilt_hi) ? tilt_hi : tilt_c1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wt <= wt_next;
      m1 <= m1_next;
      m2 <= m2_next;
      ps <= (vsaa_pkg::sum_t'(m2.cp) <<< vsaa_pkg::FRAC_BITS) + vsaa_pkg::sum_t'(m2.pm);
      ts <= (vsaa_pkg::sum_t'(m2.ct) <<< vsaa_pkg::FRAC_BITS) + vsaa_pkg::sum_t'(m2.tm);
      pr <= ps_rnd[vsaa_pkg::SUM_W-1:vsaa_pkg::FRAC_BITS];
      tr <= ts_rnd[vsaa_pkg::SUM_W-1:vsaa_pkg::FRAC_BITS];
      aim_pan <= pan_c2[vsaa_pkg::PAN_W-1:0];
      aim_tilt <= tilt_c2[vsaa_pkg::TILT_W-1:0];
    end
  end

  assign m_axis_tvalid = vld[vsaa_pkg::V_OUT];
  assign m_axis_tdata = {1'b0, aim_tilt, aim_pan};

  `VSAA_ASSERT_IMP(a_weight_range, vld[vsaa_pkg::V_WT], wt.w >= vsaa_pkg::W_MIN && wt.w <= vsaa_pkg::W_MAX)
  `VSAA_ASSERT_IMP(a_near_unit_weight, vld[vsaa_pkg::V_WT] && wt.near, wt.w == vsaa_pkg::W_ONE)
  `VSAA_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld))

endmodule
